### hw/rtl/skrt_pkg.sv
// ----------------------------------------------------------------------------
// skrt_pkg: shared types and constants for the sorted key record table
// Record layout, command and result types, status codes, controller ops.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 16;
  localparam int SCORE_W   = 10;
  localparam int IN_DATA_W  = 64;   // 58 payload bits padded to bytes
  localparam int OUT_DATA_W = 64;   // 59 payload bits padded to bytes

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] a;
    logic [SCORE_W-1:0] b;
    logic [SCORE_W-1:0] c;
  } rec_t;

  typedef struct packed {
    mode_t                     mode;
    logic [KEY_W-1:0]          key;
    logic [SCORE_W-1:0]        new_score_a;
    logic [SCORE_W-1:0]        new_score_b;
    logic [SCORE_W-1:0]        new_score_c;
    logic signed [SCORE_W-1:0] delta;
  } item_t;

  typedef struct packed {
    status_t            status;
    rec_t               rec;
    logic [SCORE_W-1:0] prior_score_a;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_UP_INIT,
    OP_UP,
    OP_INSERT,
    OP_MODIFY,
    OP_DN_INIT,
    OP_DN,
    OP_DELETE,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t st;
    logic    zero;   // result carries status only
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  scan_done;
    logic  hit;
    logic  full;
    logic  empty;
    logic  up_done;
    logic  dn_done;
    logic  out_free;
  } dp_sts_t;

endpackage

### hw/rtl/sorted_key_record_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_record_table_core: ordered key/score record table
// Each input transaction is one command (insert, search, modify, delete);
// each gives exactly one result transaction.
//
// Channels: s_axis carries commands, m_axis carries results. A transaction
// moves when tvalid and tready are both high at a rising clk edge.
// Commands run one at a time: s_axis_tready is high only while the
// sequencer is idle. A command walks the sorted store from entry 0 to its
// position p (one memory read per cycle), then an insert shifts
// count - p entries up and a delete shifts entries after p down (one
// entry per cycle on the single read and write port). Scan and shift read
// each stored entry at most once, but for entry p on an insert, which
// both read. s_axis_tready returns in the cycle in which m_axis_tvalid
// rises, so a new command is taken only once the last result is loaded.
// The result sits in an output register: m_axis stalls do not hold the
// next command's scan, only the hand-off of its result.
// Reset (rst, synchronous) empties the table; no clearing pass is needed,
// entries above the record count are never read.
// ----------------------------------------------------------------------------
module sorted_key_record_table_core
  import skrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] mode, [17:2] key, [27:18] new_score_a, [37:28] new_score_b,
  // [47:38] new_score_c, [57:48] delta, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [18:3] found_key, [28:19] score_a, [38:29] score_b,
  // [48:39] score_c, [58:49] prior_score_a, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  item_t   in_item;
  res_t    out_item;

  // unpack the command fields
  assign in_item.mode        = mode_t'(s_axis_tdata[1:0]);
  assign in_item.key         = s_axis_tdata[17:2];
  assign in_item.new_score_a = s_axis_tdata[27:18];
  assign in_item.new_score_b = s_axis_tdata[37:28];
  assign in_item.new_score_c = s_axis_tdata[47:38];
  assign in_item.delta       = s_axis_tdata[57:48];

  skrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skrt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_item  (out_item)
  );

  // pack the result, low field first, padded to whole bytes
  assign m_axis_tdata = {5'b0,
                         out_item.prior_score_a,
                         out_item.rec.c,
                         out_item.rec.b,
                         out_item.rec.a,
                         out_item.rec.key,
                         out_item.status};

endmodule

### hw/rtl/skrt_ctrl.sv
// ----------------------------------------------------------------------------
// skrt_ctrl: command sequencer
// Steps one transaction through scan, decision, shift/update and result.
// ----------------------------------------------------------------------------
module skrt_ctrl
  import skrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_UP     = 9'b000001000,
    S_INS    = 9'b000010000,
    S_MOD    = 9'b000100000,
    S_DN     = 9'b001000000,
    S_DEL    = 9'b010000000,
    S_RES    = 9'b100000000
  } state_t;

  state_t  state, state_next;
  status_t st_r, st_r_next;
  logic    zero_r, zero_r_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    st_r_next   = st_r;
    zero_r_next = zero_r;
    cmd.op      = OP_NONE;
    cmd.st      = st_r;
    cmd.zero    = zero_r;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        st_r_next   = ST_OK;
        zero_r_next = 1'b0;
        state_next  = S_RES;
        if (sts.mode == MODE_INSERT) begin
          priority if (sts.hit) begin
            st_r_next = ST_DUP;
          end else if (sts.full) begin
            st_r_next   = ST_FULL;
            zero_r_next = 1'b1;
          end else begin
            cmd.op     = OP_UP_INIT;
            state_next = S_UP;
          end
        end else begin
          priority if (sts.empty) begin
            st_r_next   = ST_EMPTY;
            zero_r_next = 1'b1;
          end else if (!sts.hit) begin
            st_r_next   = ST_MISSING;
            zero_r_next = 1'b1;
          end else if (sts.mode == MODE_MODIFY) begin
            state_next = S_MOD;
          end else if (sts.mode == MODE_DELETE) begin
            cmd.op     = OP_DN_INIT;
            state_next = S_DN;
          end else begin
            state_next = S_RES;   // search hit
          end
        end
      end
      S_UP: begin
        cmd.op = OP_UP;
        if (sts.up_done) state_next = S_INS;
      end
      S_INS: begin
        cmd.op     = OP_INSERT;
        state_next = S_RES;
      end
      S_MOD: begin
        cmd.op     = OP_MODIFY;
        state_next = S_RES;
      end
      S_DN: begin
        cmd.op = OP_DN;
        if (sts.dn_done) state_next = S_DEL;
      end
      S_DEL: begin
        cmd.op     = OP_DELETE;
        state_next = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      st_r   <= ST_OK;
      zero_r <= 1'b0;
    end else begin
      state  <= state_next;
      st_r   <= st_r_next;
      zero_r <= zero_r_next;
    end
  end

endmodule

### hw/rtl/skrt_dp.sv
// ----------------------------------------------------------------------------
// skrt_dp: record store and datapath
// Sorted record memory, pipelined scan and shift walkers, score update,
// result holding register.
// ----------------------------------------------------------------------------
module skrt_dp
  import skrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  input  item_t   in_item,
  output dp_sts_t sts,
  input  logic    out_ready,
  output logic    out_valid,
  output res_t    out_item
);

  rec_t mem [CAPACITY];

  item_t              cmd_r;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rp;        // walker read pointer
  logic               pend;      // read issued last cycle
  logic [IDX_W-1:0]   pend_idx;
  logic [CNT_W-1:0]   pos;
  logic               hit;
  rec_t               rec_r;
  logic [SCORE_W-1:0] prior;
  rec_t               rd_data;

  logic               ge, eq, scan_done, up_done, dn_done, out_free;
  logic               rd_en, we;
  logic [IDX_W-1:0]   rd_addr, wa;
  rec_t               wd;
  logic [CNT_W-1:0]   rp_dec;
  logic signed [SCORE_W+1:0] sum;
  logic [SCORE_W-1:0] new_a;

  assign ge        = rd_data.key >= cmd_r.key;
  assign eq        = rd_data.key == cmd_r.key;
  assign scan_done = pend ? ge : (rp == count);
  assign up_done   = !pend && (rp == pos);
  assign dn_done   = !pend && (rp >= count);
  assign out_free  = !out_valid || out_ready;
  assign rp_dec    = rp - CNT_W'(1);

  // saturating add of the signed delta to score a
  assign sum = $signed({2'b00, rec_r.a}) + $signed({{2{cmd_r.delta[SCORE_W-1]}}, cmd_r.delta});
  always_comb begin
    priority if (sum[SCORE_W+1]) new_a = '0;
    else if (sum[SCORE_W])       new_a = '1;
    else                         new_a = sum[SCORE_W-1:0];
  end

  assign sts.mode      = cmd_r.mode;
  assign sts.scan_done = scan_done;
  assign sts.hit       = hit;
  assign sts.full      = (count == CNT_W'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.up_done   = up_done;
  assign sts.dn_done   = dn_done;
  assign sts.out_free  = out_free;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rp[IDX_W-1:0];
    unique case (cmd.op)
      OP_SCAN: rd_en = !scan_done && (rp < count);
      OP_UP: begin
        rd_en   = rp > pos;
        rd_addr = rp_dec[IDX_W-1:0];
      end
      OP_DN:   rd_en = rp < count;
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = pos[IDX_W-1:0];
    wd = rd_data;
    unique case (cmd.op)
      OP_UP: begin
        we = pend;
        wa = pend_idx + IDX_W'(1);
      end
      OP_DN: begin
        we = pend;
        wa = pend_idx - IDX_W'(1);
      end
      OP_INSERT: begin
        we = 1'b1;
        wd = '{key: cmd_r.key, a: cmd_r.new_score_a, b: cmd_r.new_score_b,
               c: cmd_r.new_score_c};
      end
      OP_MODIFY: begin
        we = 1'b1;
        wd = '{key: rec_r.key, a: new_a, b: rec_r.b, c: rec_r.c};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= rd_en;
      if (cmd.op == OP_INSERT) count <= count + CNT_W'(1);
      if (cmd.op == OP_DELETE) count <= count - CNT_W'(1);
      if (cmd.op == OP_RESULT) out_valid <= 1'b1;
      else if (out_ready)      out_valid <= 1'b0;
    end
  end

  // walker and payload
  always_ff @(posedge clk) begin
    if (rd_en) pend_idx <= rd_addr;
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r <= in_item;
        rp    <= '0;
      end
      OP_SCAN: begin
        if (scan_done) begin
          pos   <= (pend && ge) ? CNT_W'(pend_idx) : count;
          hit   <= pend && eq;
          rec_r <= rd_data;
          prior <= rd_data.a;
        end else if (rd_en) begin
          rp <= rp + CNT_W'(1);
        end
      end
      OP_UP_INIT: rp <= count;
      OP_UP:      if (rd_en) rp <= rp_dec;
      OP_DN_INIT: rp <= pos + CNT_W'(1);
      OP_DN:      if (rd_en) rp <= rp + CNT_W'(1);
      OP_INSERT: begin
        rec_r <= '{key: cmd_r.key, a: cmd_r.new_score_a, b: cmd_r.new_score_b,
                   c: cmd_r.new_score_c};
        prior <= cmd_r.new_score_a;
      end
      OP_MODIFY:  rec_r.a <= new_a;
      OP_RESULT: begin
        out_item.status        <= cmd.st;
        out_item.rec           <= cmd.zero ? '0 : rec_r;
        out_item.prior_score_a <= cmd.zero ? '0 : prior;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_delete_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DELETE |-> count != '0)
    else $error("delete on empty table");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_RESULT |-> out_free)
    else $error("result overwrote a pending result");

endmodule

### tb/tb_sorted_key_record_table_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_record_table_core: self-checking bench for the record table
// A directed table of commands exercises the empty, missing, duplicate and
// saturation cases. Random phases then fill the table to capacity, drain it
// and mix commands with random idling on both streams. Every result is
// checked against a shadow copy of the sorted table or a typed result.
// ----------------------------------------------------------------------------
module tb_sorted_key_record_table_core;
  import skrt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
  localparam int STALL_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 24;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  typedef struct {
    item_t cmd;
    bit    fixed;   // use the typed result instead of the shadow table
    res_t  want;
  } stim_row_t;

  // shadow copy of the table, updated as each command transaction is accepted
  rec_t      shadow_store [CAPACITY];
  int        shadow_count;
  res_t      expected_results [$];
  stim_row_t stim_table [$];

  int error_count;
  int commands_sent;
  int results_checked;
  int status_hits [5];
  int idle_cycles;
  bit quiet_tail;
  bit stall_armed;

  sorted_key_record_table_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow table: works out the result of one command and updates the copy
  // --------------------------------------------------------------------------
  function automatic res_t apply_command(item_t cmd);
    res_t r;
    rec_t victim;
    int   pos;
    bit   hit;
    int   sum;
    r = '0;
    pos = 0;
    while (pos < shadow_count && shadow_store[pos].key < cmd.key) pos++;
    hit = (pos < shadow_count) && (shadow_store[pos].key == cmd.key);
    if (cmd.mode == MODE_INSERT) begin
      if (hit) begin
        r.status = ST_DUP;
        r.rec = shadow_store[pos];
        r.prior_score_a = shadow_store[pos].a;
      end else if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        for (int i = shadow_count; i > pos; i--) shadow_store[i] = shadow_store[i-1];
        shadow_store[pos] = '{cmd.key, cmd.new_score_a, cmd.new_score_b, cmd.new_score_c};
        shadow_count++;
        r.status = ST_OK;
        r.rec = shadow_store[pos];
        r.prior_score_a = cmd.new_score_a;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else if (!hit) begin
      r.status = ST_MISSING;
    end else begin
      r.status = ST_OK;
      case (cmd.mode)
        MODE_SEARCH: begin
          r.rec = shadow_store[pos];
          r.prior_score_a = shadow_store[pos].a;
        end
        MODE_MODIFY: begin
          r.prior_score_a = shadow_store[pos].a;
          sum = int'(shadow_store[pos].a) + int'($signed(cmd.delta));
          if (sum < 0) sum = 0;
          if (sum > 1023) sum = 1023;
          shadow_store[pos].a = SCORE_W'(sum);
          r.rec = shadow_store[pos];
        end
        default: begin
          victim = shadow_store[pos];
          for (int i = pos; i < shadow_count - 1; i++) shadow_store[i] = shadow_store[i+1];
          shadow_count--;
          shadow_store[shadow_count] = '0;
          r.rec = victim;
          r.prior_score_a = victim.a;
        end
      endcase
    end
    return r;
  endfunction

  function automatic item_t make_command(mode_t m, logic [KEY_W-1:0] k,
                                         logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b,
                                         logic [SCORE_W-1:0] c, logic [SCORE_W-1:0] d);
    item_t cmd;
    cmd.mode = m;
    cmd.key = k;
    cmd.new_score_a = a;
    cmd.new_score_b = b;
    cmd.new_score_c = c;
    cmd.delta = d;
    return cmd;
  endfunction

  function automatic res_t make_result(status_t st, logic [KEY_W-1:0] k,
                                       logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b,
                                       logic [SCORE_W-1:0] c, logic [SCORE_W-1:0] prior);
    res_t r;
    r.status = st;
    r.rec = '{k, a, b, c};
    r.prior_score_a = prior;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_command(item_t cmd);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[1:0]   = cmd.mode;
    d[17:2]  = cmd.key;
    d[27:18] = cmd.new_score_a;
    d[37:28] = cmd.new_score_b;
    d[47:38] = cmd.new_score_c;
    d[57:48] = cmd.delta;
    return d;
  endfunction

  function automatic logic [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SCORE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0:       return 10'h200;   // -512
      1:       return 10'h1FF;   // +511
      2:       return '0;
      default: return SCORE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // keys already in the table at the given percentage, otherwise anywhere including the ends
  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    if (shadow_count > 0 && $urandom_range(0, 99) < hit_pct)
      return shadow_store[$urandom_range(0, shadow_count - 1)].key;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return KEY_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Command stream: optional gap, then offer until the transaction is taken
  // --------------------------------------------------------------------------
  task automatic send_command(item_t cmd, bit fixed, res_t want);
    res_t predicted;
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tdata  <= pack_command(cmd);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_command(cmd);
    if (fixed) predicted = want;
    expected_results.push_back(predicted);
    status_hits[predicted.status]++;
    commands_sent++;
  endtask

  task automatic send_random(int insert_pct);
    mode_t m;
    if ($urandom_range(0, 99) < insert_pct) m = MODE_INSERT;
    else m = mode_t'($urandom_range(1, 3));
    send_command(make_command(m, pick_key(m == MODE_INSERT ? 30 : 75), rand_score(),
                              rand_score(), rand_score(), rand_delta()), 1'b0, '0);
  endtask

  task automatic add_row(item_t cmd, bit fixed, res_t want);
    stim_row_t row;
    row.cmd = cmd;
    row.fixed = fixed;
    row.want = want;
    stim_table.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Result stream: checked field by field against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with none expected", m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        check_field("status", KEY_W'(m_axis_tdata[2:0]), KEY_W'(want.status));
        check_field("found_key", m_axis_tdata[18:3], want.rec.key);
        check_field("score_a", KEY_W'(m_axis_tdata[28:19]), KEY_W'(want.rec.a));
        check_field("score_b", KEY_W'(m_axis_tdata[38:29]), KEY_W'(want.rec.b));
        check_field("score_c", KEY_W'(m_axis_tdata[48:39]), KEY_W'(want.rec.c));
        check_field("prior_score_a", KEY_W'(m_axis_tdata[58:49]),
                    KEY_W'(want.prior_score_a));
        check_field("padding", KEY_W'(m_axis_tdata[63:59]), '0);
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, none at the end
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (quiet_tail) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if (stall_armed) begin
        stall_armed = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int full_visits;
    shadow_count = 0;
    for (int i = 0; i < CAPACITY; i++) shadow_store[i] = '0;

    // directed commands; typed results only where they are obvious
    add_row(make_command(MODE_SEARCH, 16'h0000, 0, 0, 0, 0), 1,
            make_result(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_MODIFY, 16'h1234, 0, 0, 0, 10'h1FF), 1,
            make_result(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_DELETE, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF), 1,
            make_result(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_INSERT, 16'h8000, 10'h155, 10'h2AA, 10'h3FF, 10'h2AA), 1,
            make_result(ST_OK, 16'h8000, 10'h155, 10'h2AA, 10'h3FF, 10'h155));
    add_row(make_command(MODE_INSERT, 16'h0000, 10'h3FF, 10'h000, 10'h3FF, 0), 1,
            make_result(ST_OK, 16'h0000, 10'h3FF, 10'h000, 10'h3FF, 10'h3FF));
    add_row(make_command(MODE_INSERT, 16'hFFFF, 10'h000, 10'h3FF, 10'h000, 10'h155), 1,
            make_result(ST_OK, 16'hFFFF, 10'h000, 10'h3FF, 10'h000, 10'h000));
    // duplicate: the stored record comes back untouched
    add_row(make_command(MODE_INSERT, 16'h0000, 10'h005, 10'h006, 10'h007, 0), 1,
            make_result(ST_DUP, 16'h0000, 10'h3FF, 10'h000, 10'h3FF, 10'h3FF));
    add_row(make_command(MODE_SEARCH, 16'h0064, 0, 0, 0, 0), 1,
            make_result(ST_MISSING, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_SEARCH, 16'hFFFF, 10'h3FF, 0, 0, 0), 0, '0);
    // saturation at the top, then the most negative delta, then the floor
    add_row(make_command(MODE_MODIFY, 16'h0000, 0, 0, 0, 10'h1FF), 1,
            make_result(ST_OK, 16'h0000, 10'h3FF, 10'h000, 10'h3FF, 10'h3FF));
    add_row(make_command(MODE_MODIFY, 16'h0000, 0, 0, 0, 10'h200), 1,
            make_result(ST_OK, 16'h0000, 10'h1FF, 10'h000, 10'h3FF, 10'h3FF));
    add_row(make_command(MODE_MODIFY, 16'hFFFF, 0, 0, 0, 10'h200), 1,
            make_result(ST_OK, 16'hFFFF, 10'h000, 10'h3FF, 10'h000, 10'h000));
    add_row(make_command(MODE_MODIFY, 16'hFFFF, 0, 0, 0, 10'h3FF), 0, '0);
    add_row(make_command(MODE_MODIFY, 16'h8000, 0, 0, 0, 10'h000), 0, '0);
    add_row(make_command(MODE_INSERT, 16'h0001, 10'h0AA, 10'h155, 10'h001, 0), 0, '0);
    add_row(make_command(MODE_INSERT, 16'h7FFF, 10'h200, 10'h1FF, 10'h3FE, 0), 0, '0);
    add_row(make_command(MODE_DELETE, 16'h8000, 0, 0, 0, 0), 0, '0);
    add_row(make_command(MODE_DELETE, 16'h0000, 0, 0, 0, 0), 1,
            make_result(ST_OK, 16'h0000, 10'h1FF, 10'h000, 10'h3FF, 10'h1FF));
    add_row(make_command(MODE_DELETE, 16'hFFFF, 0, 0, 0, 0), 0, '0);
    add_row(make_command(MODE_DELETE, 16'hFFFF, 0, 0, 0, 0), 1,
            make_result(ST_MISSING, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_MODIFY, 16'h0002, 0, 0, 0, 10'h001), 1,
            make_result(ST_MISSING, 0, 0, 0, 0, 0));
    add_row(make_command(MODE_DELETE, 16'h0001, 0, 0, 0, 0), 0, '0);
    add_row(make_command(MODE_DELETE, 16'h7FFF, 0, 0, 0, 0), 0, '0);
    add_row(make_command(MODE_INSERT, 16'h1234, 10'h123, 10'h234, 10'h345, 0), 0, '0);
    add_row(make_command(MODE_DELETE, 16'h1234, 0, 0, 0, 0), 0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_command(stim_table[i].cmd, stim_table[i].fixed,
                                         stim_table[i].want);

    // mixed traffic that tends to grow the table
    repeat (280) send_random(45);

    // fill to capacity, then run against the full table
    full_visits = 0;
    while (shadow_count < CAPACITY)
      send_command(make_command(MODE_INSERT, pick_key(0), rand_score(), rand_score(),
                                rand_score(), rand_delta()), 1'b0, '0);
    repeat (24) begin
      send_random(60);
      if (shadow_count == CAPACITY) full_visits++;
    end

    // long receiver hold-off while commands keep coming
    stall_armed = 1'b1;
    repeat (30) send_random(40);

    // drain to empty, with random commands thrown in
    while (shadow_count > 0) begin
      if ($urandom_range(0, 5) == 0) send_random(0);
      else send_command(make_command(MODE_DELETE, pick_key(100), rand_score(), rand_score(),
                                     rand_score(), rand_delta()), 1'b0, '0);
    end
    repeat (6) send_random(20);

    repeat (250) send_random(35);

    // back-to-back finish: no idling on either side
    quiet_tail = 1'b1;
    repeat (100) send_random(40);
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands, %0d results checked, %0d commands on a full table",
             commands_sent, results_checked, full_visits);
    $display("Status mix: ok %0d, duplicate %0d, missing %0d, empty %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_DUP], status_hits[ST_MISSING],
             status_hits[ST_EMPTY], status_hits[ST_FULL]);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
